@@ rtl/core/checked_number_field_parser_macros.svh @@
// Assertion helpers shared by the checked number field parser.
`ifndef CHECKED_NUMBER_FIELD_PARSER_MACROS_SVH
`define CHECKED_NUMBER_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CNFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CNFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cnfp_pkg.sv @@
package cnfp_pkg;

  localparam int unsigned NUM_W      = 64;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned VCNT_W     = 4;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 2;

  // value formats
  localparam logic [1:0] FMT_AMOUNT = 2'd0;
  localparam logic [1:0] FMT_PLAIN  = 2'd1;
  localparam logic [1:0] FMT_VARINT = 2'd2;
  localparam logic [1:0] FMT_UNSUP  = 2'd3;

  // validation modes
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_LENGTH  = 2'd1;
  localparam logic [1:0] MODE_NUMBER  = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOWER  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_UPPER  = 2'd3;

  localparam logic [VCNT_W-1:0] VARINT_MAX_BYTES = 4'd9;
  localparam logic [CNT_W-1:0]  FIXED_LEN        = 8'd8;
  localparam logic [CNT_W-1:0]  CNT_SAT          = 8'd255;
  localparam logic [7:0]        VARINT_PAYLOAD   = 8'h7f;

  typedef struct packed {
    logic [1:0]       fmt;
    logic [1:0]       mode;
    logic [NUM_W-1:0] lower;
    logic [NUM_W-1:0] upper;
  } cfg_t;

  // state of one finished value, handed from accumulator to checker
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] cnt;
    logic             err;
    logic             done;
  } snap_t;

endpackage

@@ rtl/core/cnfp_if.sv @@
interface cnfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cnfp_result_if;
  logic                        valid;
  logic                        ready;
  logic [cnfp_pkg::NUM_W-1:0]  number_value;
  logic                        invalid_data;

  modport source (output valid, number_value, invalid_data, input ready);
  modport sink   (input valid, number_value, invalid_data, output ready);
endinterface

@@ rtl/core/checked_number_field_parser.sv @@
// Path: the last byte of a value loads the snapshot register, and the check
// stage then loads the result word into the output register once it is free.
// Throughput: one byte per cycle; the check stage and output register each
// hold one value, so backpressure stalls input only when both are full.
// Reset: synchronous, active low; clears the value state, pipeline valids and
// all configuration registers.
`include "checked_number_field_parser_macros.svh"

module checked_number_field_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  cnfp_byte_if.sink                        in_if,
  cnfp_result_if.source                    out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cnfp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cnfp_pkg::NUM_W-1:0]       pwdata,
  output logic [cnfp_pkg::NUM_W-1:0]       prdata,
  output logic                             pready
);

  cnfp_pkg::cfg_t   cfg;
  cnfp_pkg::snap_t  snap;
  logic             can_load;
  logic             accept;
  logic             snap_valid;

  // Register file: format, mode and the two 64-bit bounds, one per 8 bytes.
  cnfp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take a word whenever the check stage can take a snapshot this cycle;
  // non-last words only advance the accumulator but share the same gate.
  assign in_if.ready = can_load;
  assign accept      = in_if.valid && in_if.ready;

  // Accumulate fixed little-endian or LEB128 bytes; hand the finished
  // state over on the last word and drop back to empty.
  cnfp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_if.data_byte),
    .last_byte (in_if.last_byte),
    .fmt       (cfg.fmt),
    .snap      (snap)
  );

  // Run the length, range and format checks on the held snapshot and
  // load the result register; zero the number on any failure.
  cnfp_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept && in_if.last_byte),
    .snap         (snap),
    .cfg          (cfg),
    .out_ready    (out_if.ready),
    .can_load     (can_load),
    .snap_valid   (snap_valid),
    .out_valid    (out_if.valid),
    .number_value (out_if.number_value),
    .invalid_data (out_if.invalid_data)
  );

  `CNFP_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_if.valid && out_if.invalid_data, out_if.number_value == '0, "failed value carries a nonzero number")
  `CNFP_ASSERT_NEXT(a_last_snap, clk, rst_n, accept && in_if.last_byte, snap_valid, "last word did not reach the check stage")
  `CNFP_ASSERT_IMPL(a_full_stall, clk, rst_n, snap_valid && out_if.valid && !out_if.ready, !in_if.ready, "input open while both stages are full")

endmodule

@@ rtl/core/cnfp_cfg.sv @@
module cnfp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cnfp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cnfp_pkg::NUM_W-1:0]       pwdata,
  output logic [cnfp_pkg::NUM_W-1:0]       prdata,
  output logic                             pready,
  output cnfp_pkg::cfg_t                   cfg
);

  cnfp_pkg::cfg_t                   cfg_r;
  logic                             wr_en;
  logic [cnfp_pkg::REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[cnfp_pkg::CFG_ADDR_W-1:3];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        cnfp_pkg::REG_FORMAT: cfg_r.fmt   <= pwdata[1:0];
        cnfp_pkg::REG_MODE:   cfg_r.mode  <= pwdata[1:0];
        cnfp_pkg::REG_LOWER:  cfg_r.lower <= pwdata;
        cnfp_pkg::REG_UPPER:  cfg_r.upper <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cnfp_pkg::REG_FORMAT: prdata = {{(cnfp_pkg::NUM_W-2){1'b0}}, cfg_r.fmt};
      cnfp_pkg::REG_MODE:   prdata = {{(cnfp_pkg::NUM_W-2){1'b0}}, cfg_r.mode};
      cnfp_pkg::REG_LOWER:  prdata = cfg_r.lower;
      cnfp_pkg::REG_UPPER:  prdata = cfg_r.upper;
      default:              prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/cnfp_accum.sv @@
module cnfp_accum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [1:0]            fmt,
  output cnfp_pkg::snap_t       snap
);

  logic [cnfp_pkg::NUM_W-1:0]   acc_r, acc_nxt;
  logic [cnfp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [cnfp_pkg::VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic                         done_r, done_nxt;
  logic                         err_r, err_nxt;
  logic [6:0]                   vshift;
  logic [5:0]                   fshift;

  // 7 * varint byte index, and 8 * fixed byte index
  assign vshift = ({3'b000, vcnt_r} << 3) - {3'b000, vcnt_r};
  assign fshift = {cnt_r[2:0], 3'b000};

  always_comb begin
    acc_nxt  = acc_r;
    vcnt_nxt = vcnt_r;
    done_nxt = done_r;
    err_nxt  = err_r;
    if (fmt == cnfp_pkg::FMT_VARINT) begin
      if (done_r) begin
        err_nxt = 1'b1;
      end else if (!err_r && (vcnt_r < cnfp_pkg::VARINT_MAX_BYTES)) begin
        acc_nxt  = acc_r | ({56'd0, data_byte & cnfp_pkg::VARINT_PAYLOAD} << vshift);
        vcnt_nxt = vcnt_r + 1'b1;
        if (!data_byte[7]) begin
          done_nxt = 1'b1;
        end else if (vcnt_nxt >= cnfp_pkg::VARINT_MAX_BYTES) begin
          err_nxt = 1'b1;
        end
      end
    end else if (cnt_r < cnfp_pkg::FIXED_LEN) begin
      acc_nxt = acc_r | ({56'd0, data_byte} << fshift);
    end
    cnt_nxt = (cnt_r == cnfp_pkg::CNT_SAT) ? cnt_r : cnt_r + 1'b1;
  end

  assign snap.num  = acc_nxt;
  assign snap.cnt  = cnt_nxt;
  assign snap.err  = err_nxt;
  assign snap.done = done_nxt;

  // clear on the last word of a value, else advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      vcnt_r <= '0;
      done_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        acc_r  <= '0;
        cnt_r  <= '0;
        vcnt_r <= '0;
        done_r <= 1'b0;
        err_r  <= 1'b0;
      end else begin
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        vcnt_r <= vcnt_nxt;
        done_r <= done_nxt;
        err_r  <= err_nxt;
      end
    end
  end

endmodule

@@ rtl/core/cnfp_check.sv @@
module cnfp_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  cnfp_pkg::snap_t             snap,
  input  cnfp_pkg::cfg_t              cfg,
  input  logic                        out_ready,
  output logic                        can_load,
  output logic                        snap_valid,
  output logic                        out_valid,
  output logic [cnfp_pkg::NUM_W-1:0]  number_value,
  output logic                        invalid_data
);

  cnfp_pkg::snap_t              snap_r;
  logic                         snap_valid_r;
  logic                         out_valid_r;
  logic [cnfp_pkg::NUM_W-1:0]   num_r;
  logic                         bad_r;
  logic                         advance;
  logic                         bad;
  logic [cnfp_pkg::NUM_W-1:0]   cnt_ext;

  assign advance  = snap_valid_r && (!out_valid_r || out_ready);
  assign can_load = !snap_valid_r || advance;
  assign cnt_ext  = {{(cnfp_pkg::NUM_W-cnfp_pkg::CNT_W){1'b0}}, snap_r.cnt};

  always_comb begin
    bad = (snap_r.cnt == cnfp_pkg::CNT_SAT);
    case (cfg.mode)
      cnfp_pkg::MODE_NONE:
        if ((cfg.lower != '0) || (cfg.upper != '0)) bad = 1'b1;
      cnfp_pkg::MODE_LENGTH:
        if ((cfg.lower > cnt_ext) || (cfg.upper < cnt_ext)) bad = 1'b1;
      cnfp_pkg::MODE_NUMBER:
        if ((snap_r.num < cfg.lower) || (snap_r.num > cfg.upper)) bad = 1'b1;
      default: bad = 1'b1;
    endcase
    case (cfg.fmt) inside
      cnfp_pkg::FMT_AMOUNT, cnfp_pkg::FMT_PLAIN:
        if (snap_r.cnt != cnfp_pkg::FIXED_LEN) bad = 1'b1;
      cnfp_pkg::FMT_VARINT:
        if (snap_r.err || !snap_r.done || (snap_r.num[cnfp_pkg::NUM_W-1:32] != '0)) bad = 1'b1;
      default: bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load) begin
        snap_valid_r <= 1'b1;
      end else if (advance) begin
        snap_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap_r <= snap;
    end
    if (advance) begin
      num_r <= bad ? '0 : snap_r.num;
      bad_r <= bad;
    end
  end

  assign snap_valid   = snap_valid_r;
  assign out_valid    = out_valid_r;
  assign number_value = num_r;
  assign invalid_data = bad_r;

endmodule
